### rtl/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and codes for the text console cursor and scroll unit.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// command codes carried on the input tuser
	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// character codes with special handling
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// attribute used for the blanks written right after reset
	localparam logic [7:0] RESET_ATTR = 8'h0F;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_READ,
		ST_RESP
	} state_t;

	// request from the sequencer to the sweep unit
	typedef struct packed {
		logic start;
		logic scroll;
	} sweep_cmd_t;

endpackage

### rtl/tccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/tccs_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_cursor
// Cursor update for one put byte: control codes, printing, wrap, scroll flag.
// ----------------------------------------------------------------------------
module tccs_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_WIDTH = 8,
	localparam int COL_W = $clog2(COLUMNS + TAB_WIDTH),
	localparam int ROW_W = $clog2(ROWS + 1),
	localparam int PH_W = $clog2(TAB_WIDTH)
) (
	input  logic [COL_W-1:0] col,
	input  logic [ROW_W-1:0] line,
	input  logic [PH_W-1:0]  phase,
	input  logic [7:0]       char_code,
	output logic [COL_W-1:0] nxt_col,
	output logic [ROW_W-1:0] nxt_line,
	output logic [PH_W-1:0]  nxt_phase,
	output logic             write_char,
	output logic             scroll
);

	logic [COL_W-1:0] col_a;
	logic [ROW_W-1:0] line_a;
	logic [PH_W-1:0]  ph_a;
	logic [COL_W-1:0] col_b;
	logic [ROW_W-1:0] line_b;
	logic [PH_W-1:0]  ph_b;

	// per-byte rule; phase tracks the column modulo the tab width
	always_comb begin
		col_a = col;
		line_a = line;
		ph_a = phase;
		write_char = 1'b0;
		case (char_code)
			tccs_pkg::CH_BS: begin
				if (col != '0) begin
					col_a = col - COL_W'(1);
					ph_a = (phase == '0) ? PH_W'(TAB_WIDTH - 1) : phase - PH_W'(1);
				end
			end
			tccs_pkg::CH_TAB: begin
				col_a = col + COL_W'(TAB_WIDTH) - COL_W'(phase);
				ph_a = '0;
			end
			tccs_pkg::CH_CR: begin
				col_a = '0;
				ph_a = '0;
			end
			tccs_pkg::CH_LF: begin
				col_a = '0;
				line_a = line + ROW_W'(1);
				ph_a = '0;
			end
			default: begin
				if (!char_code[7] && char_code >= tccs_pkg::CH_SPACE) begin
					write_char = 1'b1;
					col_a = col + COL_W'(1);
					ph_a = (phase == PH_W'(TAB_WIDTH - 1)) ? '0 : phase + PH_W'(1);
				end
			end
		endcase
	end

	// column wrap, then row overflow
	always_comb begin
		col_b = col_a;
		line_b = line_a;
		ph_b = ph_a;
		if (col_a >= COL_W'(COLUMNS)) begin
			col_b = '0;
			line_b = line_a + ROW_W'(1);
			ph_b = '0;
		end
		scroll = (line_b >= ROW_W'(ROWS));
		nxt_col = col_b;
		nxt_phase = ph_b;
		nxt_line = scroll ? ROW_W'(ROWS - 1) : line_b;
	end

endmodule

### rtl/tccs_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_sweep
// Address walker over the whole cell store: blank fill or scroll-up copy,
// one cell per cycle with the write in the cycle after the read.
// ----------------------------------------------------------------------------
module tccs_sweep #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int CELL_COUNT = COLUMNS * ROWS,
	localparam int COPY_CELLS = (ROWS - 1) * COLUMNS,
	localparam int ADDR_W = $clog2(CELL_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tccs_pkg::sweep_cmd_t cmd,
	input  logic [15:0]          blank,
	input  logic [15:0]          rd_data,
	output logic [ADDR_W-1:0]    rd_addr,
	output logic                 wr_en,
	output logic [ADDR_W-1:0]    wr_addr,
	output logic [15:0]          wr_data,
	output logic                 done
);

	logic              run_q;
	logic              scroll_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              copy_cell;
	logic              wr_en_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              from_ram_s1;

	// the copy region is every row but the last
	assign copy_cell = scroll_q && (ptr_q < ADDR_W'(COPY_CELLS));
	assign rd_addr = copy_cell ? ptr_q + ADDR_W'(COLUMNS) : '0;

	// pointer walk; after reset a blank fill runs at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b1;
			scroll_q <= 1'b0;
			ptr_q <= '0;
		end else if (cmd.start) begin
			run_q <= 1'b1;
			scroll_q <= cmd.scroll;
			ptr_q <= '0;
		end else if (run_q) begin
			ptr_q <= ptr_q + ADDR_W'(1);
			if (ptr_q == ADDR_W'(CELL_COUNT - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// write stage, aligned with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= ptr_q;
		from_ram_s1 <= copy_cell;
	end

	assign wr_en = wr_en_s1;
	assign wr_addr = wr_addr_s1;
	assign wr_data = from_ram_s1 ? rd_data : blank;
	assign done = wr_en_s1 && !run_q;

endmodule

### rtl/text_console_cursor_scroll_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Text terminal engine: cell store with cursor, put/clear/read commands,
// line wrap and scroll-up.
// ----------------------------------------------------------------------------
// channel   direction  signals                     contents
// s_*       in         s_tvalid/s_tready/s_tdata   char_code, read_index
//                      s_tuser                     cmd
// m_*       out        m_tvalid/m_tready/m_tdata   cursor, cell_data, did_scroll
// cfg_*     in         cfg_we/cfg_wdata            text_attribute
//
// A put without scroll goes through ST_EXEC and ST_RESP, a valid read also ST_READ.
// Clear and scroll walk the cell store one cell per cycle through the sweep
// unit and the single RAM write port. After reset the store is blanked by
// the same walk before s_tready rises; cfg writes are taken throughout.
// A result waiting in the output register does not hold off the next command.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], read_index[18:8], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cursor_location[10:0], cursor_column[17:11],
	                               // cursor_line[22:18], cell_data[38:23],
	                               // did_scroll[39]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int COL_W = $clog2(COLUMNS + TAB_WIDTH);
	localparam int ROW_W = $clog2(ROWS + 1);
	localparam int PH_W = $clog2(TAB_WIDTH);

	tccs_pkg::state_t     state_q;
	tccs_pkg::state_t     state_d;
	tccs_pkg::sweep_cmd_t sw_cmd;

	logic [7:0]        attr_q;
	logic [1:0]        cmd_q;
	logic [7:0]        char_q;
	logic [10:0]       ridx_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  line_q;
	logic [PH_W-1:0]   phase_q;
	logic              did_scroll_q;
	logic [15:0]       cell_q;
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;

	logic [COL_W-1:0]  cur_col;
	logic [ROW_W-1:0]  cur_line;
	logic [PH_W-1:0]   cur_phase;
	logic              cur_wr;
	logic              cur_scroll;

	logic [ADDR_W-1:0] loc;
	logic              read_ok;
	logic              out_free;
	logic              accept;
	logic              exec_put;
	logic              exec_clear;
	logic              exec_read;
	logic              put_we;
	logic              out_load;

	logic [15:0]       blank;
	logic [ADDR_W-1:0] sw_rd_addr;
	logic              sw_wr_en;
	logic [ADDR_W-1:0] sw_wr_addr;
	logic [15:0]       sw_wr_data;
	logic              sw_done;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	// linear cursor position
	assign loc = ADDR_W'(line_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign read_ok = 32'(ridx_q) < CELL_COUNT;
	assign out_free = !m_tvalid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	// cursor rules for the latched byte
	tccs_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) u_cursor (
		.col(col_q),
		.line(line_q),
		.phase(phase_q),
		.char_code(char_q),
		.nxt_col(cur_col),
		.nxt_line(cur_line),
		.nxt_phase(cur_phase),
		.write_char(cur_wr),
		.scroll(cur_scroll)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tccs_pkg::ST_INIT: begin
				if (sw_done) begin
					state_d = tccs_pkg::ST_IDLE;
				end
			end
			tccs_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = tccs_pkg::ST_EXEC;
				end
			end
			tccs_pkg::ST_EXEC: begin
				case (cmd_q)
					tccs_pkg::CMD_PUT: begin
						state_d = cur_scroll ? tccs_pkg::ST_SWEEP : tccs_pkg::ST_RESP;
					end
					tccs_pkg::CMD_CLEAR: begin
						state_d = tccs_pkg::ST_SWEEP;
					end
					tccs_pkg::CMD_READ: begin
						state_d = read_ok ? tccs_pkg::ST_READ : tccs_pkg::ST_RESP;
					end
					default: begin
						state_d = tccs_pkg::ST_RESP;
					end
				endcase
			end
			tccs_pkg::ST_SWEEP: begin
				if (sw_done) begin
					state_d = tccs_pkg::ST_RESP;
				end
			end
			tccs_pkg::ST_READ: begin
				state_d = tccs_pkg::ST_RESP;
			end
			tccs_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = tccs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tccs_pkg::ST_IDLE;
			end
		endcase
	end

	// state decode
	always_comb begin
		s_tready = (state_q == tccs_pkg::ST_IDLE);
		exec_put = (state_q == tccs_pkg::ST_EXEC) && (cmd_q == tccs_pkg::CMD_PUT);
		exec_clear = (state_q == tccs_pkg::ST_EXEC) && (cmd_q == tccs_pkg::CMD_CLEAR);
		exec_read = (state_q == tccs_pkg::ST_EXEC) && (cmd_q == tccs_pkg::CMD_READ);
		put_we = exec_put && cur_wr;
		sw_cmd.start = (exec_put && cur_scroll) || exec_clear;
		sw_cmd.scroll = exec_put;
		out_load = (state_q == tccs_pkg::ST_RESP) && out_free;
		blank = {(state_q == tccs_pkg::ST_INIT) ? tccs_pkg::RESET_ATTR : attr_q,
			tccs_pkg::CH_SPACE};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccs_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tccs_pkg::RESET_ATTR;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	// input transaction capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			char_q <= s_tdata[7:0];
			ridx_q <= s_tdata[18:8];
		end
	end

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			line_q <= '0;
			phase_q <= '0;
		end else if (exec_put) begin
			col_q <= cur_col;
			line_q <= cur_line;
			phase_q <= cur_phase;
		end else if (exec_clear) begin
			col_q <= '0;
			line_q <= '0;
			phase_q <= '0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == tccs_pkg::ST_EXEC) begin
			did_scroll_q <= exec_put && cur_scroll;
			cell_q <= '0;
		end else if (state_q == tccs_pkg::ST_READ) begin
			cell_q <= ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {did_scroll_q, cell_q, 5'(line_q), 7'(col_q), 11'(loc)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// fill and scroll walker
	tccs_sweep #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(sw_cmd),
		.blank(blank),
		.rd_data(ram_rdata),
		.rd_addr(sw_rd_addr),
		.wr_en(sw_wr_en),
		.wr_addr(sw_wr_addr),
		.wr_data(sw_wr_data),
		.done(sw_done)
	);

	// memory port selection
	assign ram_we = sw_wr_en || put_we;
	assign ram_waddr = sw_wr_en ? sw_wr_addr : loc;
	assign ram_wdata = sw_wr_en ? sw_wr_data : {attr_q, char_q};
	assign ram_raddr = exec_read ? ADDR_W'(ridx_q) : sw_rd_addr;

	tccs_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

### test/tccs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_checker
// Watches the command, result and attribute channels of the text console
// unit, keeps its own copy of the screen, cursor and attribute, works out the
// cursor report for each accepted command and compares every result against
// the oldest outstanding report, field by field.
// ----------------------------------------------------------------------------
module tccs_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], read_index[18:8], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // cursor_location[10:0], cursor_column[17:11],
	                               // cursor_line[22:18], cell_data[38:23],
	                               // did_scroll[39]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output int          pending,
	output int          errors
);

	localparam int CELLS = COLUMNS * ROWS;

	// one result transaction, lowest field in the lowest bits
	typedef struct packed {
		logic        did_scroll;
		logic [15:0] cell_data;
		logic [4:0]  cursor_line;
		logic [6:0]  cursor_column;
		logic [10:0] cursor_location;
	} cursor_report_t;

	logic [15:0]    screen [CELLS];
	logic [6:0]     cur_col;
	logic [4:0]     cur_row;
	logic [7:0]     attr;
	cursor_report_t expected_reports [$];

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("tccs_checker: %0t ns %s: got 0x%0h, expected 0x%0h",
			$time, what, got, want);
		errors++;
	endtask

	task automatic blank_rows(input int from);
		for (int i = from; i < CELLS; i++)
			screen[i] = {attr, tccs_pkg::CH_SPACE};
	endtask

	// next cursor, screen contents and report for one command
	task automatic console_step(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [10:0] ridx, output cursor_report_t rep);
		logic [15:0] cell_word;
		logic        scrolled;
		cell_word = '0;
		scrolled = 1'b0;
		case (cmd)
			tccs_pkg::CMD_PUT: begin
				if (ch == tccs_pkg::CH_BS) begin
					if (cur_col != 0)
						cur_col = cur_col - 7'd1;
				end else if (ch == tccs_pkg::CH_TAB) begin
					cur_col = 7'(int'(cur_col) + TAB_WIDTH - int'(cur_col) % TAB_WIDTH);
				end else if (ch == tccs_pkg::CH_CR) begin
					cur_col = '0;
				end else if (ch == tccs_pkg::CH_LF) begin
					cur_col = '0;
					cur_row = cur_row + 5'd1;
				end else if (!ch[7] && ch >= tccs_pkg::CH_SPACE) begin
					screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {attr, ch};
					cur_col = cur_col + 7'd1;
				end
				// wrap to the next row
				if (cur_col >= COLUMNS) begin
					cur_col = '0;
					cur_row = cur_row + 5'd1;
				end
				// scroll up one row and blank the bottom one
				if (cur_row >= ROWS) begin
					for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
						screen[i] = screen[i + COLUMNS];
					blank_rows((ROWS - 1) * COLUMNS);
					cur_row = 5'(ROWS - 1);
					scrolled = 1'b1;
				end
			end
			tccs_pkg::CMD_CLEAR: begin
				blank_rows(0);
				cur_col = '0;
				cur_row = '0;
			end
			tccs_pkg::CMD_READ: begin
				if (ridx < CELLS)
					cell_word = screen[ridx];
			end
			default: ;
		endcase
		rep.cursor_location = 11'(int'(cur_row) * COLUMNS + int'(cur_col));
		rep.cursor_column   = cur_col;
		rep.cursor_line     = cur_row;
		rep.cell_data       = cell_word;
		rep.did_scroll      = scrolled;
	endtask

	task automatic compare_report(input cursor_report_t got, input cursor_report_t want);
		if (got.cursor_location !== want.cursor_location)
			report_mismatch("cursor_location", 40'(got.cursor_location),
				40'(want.cursor_location));
		if (got.cursor_column !== want.cursor_column)
			report_mismatch("cursor_column", 40'(got.cursor_column),
				40'(want.cursor_column));
		if (got.cursor_line !== want.cursor_line)
			report_mismatch("cursor_line", 40'(got.cursor_line), 40'(want.cursor_line));
		if (got.cell_data !== want.cell_data)
			report_mismatch("cell_data", 40'(got.cell_data), 40'(want.cell_data));
		if (got.did_scroll !== want.did_scroll)
			report_mismatch("did_scroll", 40'(got.did_scroll), 40'(want.did_scroll));
	endtask

	// results are checked before new commands are predicted, then the attribute
	always @(posedge clk or negedge arst_n) begin : watch
		cursor_report_t got;
		cursor_report_t want;
		if (!arst_n) begin
			attr = tccs_pkg::RESET_ATTR;
			blank_rows(0);
			cur_col = '0;
			cur_row = '0;
			expected_reports.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_reports.size() == 0) begin
					report_mismatch("result with nothing outstanding", got, '0);
				end else begin
					want = expected_reports.pop_front();
					compare_report(got, want);
				end
			end
			if (s_tvalid && s_tready) begin
				console_step(s_tuser, s_tdata[7:0], s_tdata[18:8], want);
				expected_reports.push_back(want);
			end
			if (cfg_we)
				attr = cfg_wdata;
		end
		pending = expected_reports.size();
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the text console unit with a short directed run (reads at the store
// edges and past them, every byte class, cursor moves, clear, unused command)
// and then random console traffic over several attribute settings, with
// random gaps on the command side and random stalls on the result side.
// Checking is done by tccs_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS = COLUMNS * ROWS;

	localparam logic [1:0]  CMD_UNUSED        = 2'd3;
	localparam logic [7:0]  CH_LAST_CONTROL   = 8'h1F;
	localparam logic [7:0]  CH_LAST_PRINTABLE = 8'h7F;
	localparam logic [7:0]  CH_FIRST_HIGH     = 8'h80;
	localparam logic [10:0] INDEX_MAX         = 11'h7FF;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 315;
	localparam int CALM_ITEMS   = 200;
	localparam int SETTLE       = 8;
	localparam int DRAIN        = 16;
	localparam int STALL_LIMIT  = 10 * CELLS;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // char_code[7:0], read_index[18:8], zero pad
	logic [1:0]  s_tuser = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // cursor_location[10:0], cursor_column[17:11],
	                             // cursor_line[22:18], cell_data[38:23],
	                             // did_scroll[39]
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	logic        jitter = 1'b1;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int          items_sent = 0;
	int          pending;
	int          errors;

	text_console_cursor_scroll_unit #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	tccs_checker #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pending(pending),
		.errors(errors)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side stalls in random bursts, counted down in stall_left
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (jitter && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// one command transaction, with an optional gap in front
	task automatic send(input logic [1:0] cmd, input logic [7:0] code,
			input logic [10:0] index);
		if (jitter && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, index, code};
		do
			@(negedge clk);
		while (s_tready !== 1'b1);
		@(posedge clk);
		items_sent++;
	endtask

	// attribute write once every outstanding result is back
	task automatic set_attribute(input logic [7:0] value);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] printable();
		return 8'($urandom_range(tccs_pkg::CH_SPACE, CH_LAST_PRINTABLE));
	endfunction

	// mostly text with line control, some reads, rare clears and noise
	task automatic send_random_item();
		int unsigned pick;
		int          run_len;
		logic [7:0]  code;
		logic [10:0] index;
		pick = $urandom_range(0, 99);
		code = 8'($urandom);
		index = 11'($urandom);
		if (pick < 58)
			send(tccs_pkg::CMD_PUT, printable(), index);
		else if (pick < 63)
			send(tccs_pkg::CMD_PUT, tccs_pkg::CH_LF, index);
		else if (pick < 66)
			send(tccs_pkg::CMD_PUT, tccs_pkg::CH_TAB, index);
		else if (pick < 68)
			send(tccs_pkg::CMD_PUT, tccs_pkg::CH_CR, index);
		else if (pick < 71)
			send(tccs_pkg::CMD_PUT, tccs_pkg::CH_BS, index);
		else if (pick < 73)
			send(tccs_pkg::CMD_PUT, 8'($urandom_range(0, CH_LAST_CONTROL)), index);
		else if (pick < 75)
			send(tccs_pkg::CMD_PUT, 8'($urandom_range(CH_FIRST_HIGH, 8'hFF)), index);
		else if (pick < 82)
			send(tccs_pkg::CMD_READ, code,
				11'($urandom_range((ROWS - 2) * COLUMNS, CELLS - 1)));
		else if (pick < 88)
			send(tccs_pkg::CMD_READ, code, 11'($urandom_range(0, CELLS - 1)));
		else if (pick < 90)
			send(tccs_pkg::CMD_READ, code, 11'($urandom_range(CELLS, INDEX_MAX)));
		else if (pick < 91)
			send(tccs_pkg::CMD_CLEAR, code, index);
		else if (pick < 93)
			send(CMD_UNUSED, code, index);
		else if (pick < 97) begin
			// a line of text, long enough to wrap at times
			run_len = $urandom_range(10, COLUMNS + 10);
			for (int k = 0; k < run_len; k++)
				send(tccs_pkg::CMD_PUT, printable(), 11'($urandom));
			send(tccs_pkg::CMD_PUT,
				($urandom_range(0, 1) != 0) ? tccs_pkg::CH_LF : tccs_pkg::CH_CR, index);
		end else begin
			// read back a random cell and one in the bottom row
			send(tccs_pkg::CMD_READ, code, 11'($urandom_range(0, CELLS - 1)));
			send(tccs_pkg::CMD_READ, code,
				11'($urandom_range((ROWS - 1) * COLUMNS, CELLS - 1)));
		end
	endtask

	initial begin
		int phase_end;
		int total;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: store edges, every byte class, cursor moves, clear
		send(tccs_pkg::CMD_READ, 8'h00, 11'd0);
		send(tccs_pkg::CMD_READ, 8'hFF, 11'(CELLS - 1));
		send(tccs_pkg::CMD_READ, 8'h00, 11'(CELLS));
		send(tccs_pkg::CMD_READ, 8'hFF, INDEX_MAX);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_BS, INDEX_MAX);
		send(tccs_pkg::CMD_PUT, 8'h41, 11'd0);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_SPACE, 11'd0);
		send(tccs_pkg::CMD_PUT, CH_LAST_PRINTABLE, 11'd0);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_BS, 11'd0);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_CR, 11'd0);
		send(tccs_pkg::CMD_PUT, 8'h00, 11'd0);
		send(tccs_pkg::CMD_PUT, CH_LAST_CONTROL, 11'd0);
		send(tccs_pkg::CMD_PUT, CH_FIRST_HIGH, 11'd0);
		send(tccs_pkg::CMD_PUT, 8'hFF, 11'd0);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_TAB, 11'd0);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_TAB, 11'd0);
		send(tccs_pkg::CMD_PUT, tccs_pkg::CH_LF, 11'd0);
		send(CMD_UNUSED, 8'hFF, INDEX_MAX);
		send(tccs_pkg::CMD_READ, 8'h00, 11'd0);
		send(tccs_pkg::CMD_READ, 8'h00, 11'd2);
		send(tccs_pkg::CMD_CLEAR, 8'hFF, INDEX_MAX);
		send(tccs_pkg::CMD_READ, 8'h00, 11'd0);
		send(tccs_pkg::CMD_READ, 8'h00, 11'd2);

		// random traffic, one attribute per phase, quiet handshakes at the end
		total = items_sent + PHASES * PHASE_ITEMS;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_attribute(8'h00);
				1: set_attribute(8'hFF);
				default: set_attribute(8'($urandom));
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if (items_sent >= total - CALM_ITEMS)
					jitter <= 1'b0;
				else if (items_sent % 100 == 0)
					jitter <= ($urandom_range(0, 3) != 0);
				send_random_item();
			end
		end
		s_tvalid <= 1'b0;

		// drain and verdict
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
